// ----- hdl/framed_packet_receiver_assert.svh -----
// assertion macros for the framed packet receiver
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

// checked only outside reset
`define FPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define FPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/fpr_pkg.sv -----
`timescale 1ns / 1ps
package fpr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE        = 3'd0;
  localparam logic [2:0] REG_MAX_LENGTH    = 3'd1;
  localparam logic [2:0] REG_FIRST_HEADER  = 3'd2;
  localparam logic [2:0] REG_SECOND_HEADER = 3'd3;
  localparam logic [2:0] REG_END_MARKER    = 3'd4;

  // escape run bytes
  localparam logic [7:0] RUN_A = 8'hAA;
  localparam logic [7:0] RUN_B = 8'hBB;
  localparam logic [7:0] RUN_C = 8'hCC;

  // command queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       enable;
    logic [7:0] max_length;
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [7:0] end_marker;
  } cfg_t;

  // one command from front to back: a packet close or a run of stored bytes
  typedef struct packed {
    logic            is_close;
    logic [1:0]      n_m1;   // stored bytes minus one
    logic [3:0][7:0] bytes;
    logic [7:0]      start;  // first position, or packet length on close
  } cmd_t;

endpackage

// ----- hdl/framed_packet_receiver.sv -----
// framed packet receiver
// rx channel: one link byte per item on rx_byte, taken when rx_valid is high
//   and rx_stall is low. the front end classifies each byte at once: header
//   bytes, the AA BB CC escape run and the end byte are tracked here.
// result channel: one result per item on kind, payload_byte, position,
//   packet_length and last, taken when res_valid is high and res_stall low.
//   kind 0 is a stored payload byte, kind 1 closes the packet with its length;
//   last marks the final result caused by one received byte.
// timing: a byte's command is registered in the queue, then its first result
//   in the result register. throughput: one byte per cycle while each byte
//   makes at most one result and res_stall is low; a broken escape run makes
//   up to four results, which the back end plays out one per cycle unless stalled.
// a two-entry command queue sits between front and back; rx_stall rises only
//   when that queue is full, so a stalled result port backs up into rx.
// config: cfg_valid/cfg_ready write register cfg_index with cfg_data; ready
//   is always high, unknown indexes are dropped. write only while idle.
// reset (rst, synchronous): registers go to their defaults, framing state
//   returns to waiting for the opening byte, queue and result port empty.
`timescale 1ns / 1ps
`include "framed_packet_receiver_assert.svh"
module framed_packet_receiver
  import fpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // received bytes
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  // results
  output logic       res_valid,
  input  logic       res_stall,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [7:0] position,
  output logic [7:0] packet_length,
  output logic       last,
  // register writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;
  logic rx_fire;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b1;
      cfg.max_length    <= 8'd255;
      cfg.first_header  <= 8'h01;
      cfg.second_header <= 8'h02;
      cfg.end_marker    <= 8'h04;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:        cfg.enable        <= cfg_data[0];
        REG_MAX_LENGTH:    cfg.max_length    <= cfg_data;
        REG_FIRST_HEADER:  cfg.first_header  <= cfg_data;
        REG_SECOND_HEADER: cfg.second_header <= cfg_data;
        REG_END_MARKER:    cfg.end_marker    <= cfg_data;
        default:           cfg               <= cfg;
      endcase
    end
  end

  // front end takes a byte whenever the queue has room
  assign rx_stall = q_full;
  assign rx_fire  = rx_valid && !rx_stall;

  fpr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (rx_fire),
    .rx_byte (rx_byte),
    .push    (push),
    .cmd     (push_cmd)
  );

  fpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back end expands each command into results
  fpr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .position      (position),
    .packet_length (packet_length),
    .last          (last)
  );

  // a command never lands in a full queue
  `FPR_ASSERT(a_no_push_full, push |-> !q_full, "command pushed into full queue")
  // a disabled receiver makes no commands
  `FPR_ASSERT(a_disabled_quiet, (rx_fire && !cfg.enable) |-> !push, "command while disabled")
  // packet close is always the final result of its byte
  `FPR_ASSERT(a_close_last, (res_valid && kind) |-> last, "packet end not marked last")
  // result port comes out of reset empty
  `FPR_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result valid after reset")

endmodule

// ----- hdl/fpr_front.sv -----
`timescale 1ns / 1ps
module fpr_front
  import fpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic fire,
  input  logic [7:0] rx_byte,
  output logic push,
  output cmd_t cmd
);

  localparam logic [1:0] PH_WAIT_FIRST  = 2'd0;
  localparam logic [1:0] PH_WAIT_SECOND = 2'd1;
  localparam logic [1:0] PH_PAYLOAD     = 2'd2;

  logic [1:0] phase, phase_next;
  logic [1:0] progress, progress_next;
  logic [7:0] count, count_next;

  logic       full;
  logic [7:0] room;
  logic [2:0] k;
  logic [2:0] nbytes;
  logic       do_store;
  logic       do_close;

  assign full = count >= cfg.max_length;
  assign room = cfg.max_length - count;
  assign nbytes = (room < {5'd0, k}) ? room[2:0] : k;

  always_comb begin
    phase_next    = phase;
    progress_next = progress;
    count_next    = count;
    k             = 3'd1;
    do_store      = 1'b0;
    do_close      = 1'b0;
    if (cfg.enable) begin
      unique case (phase)
        PH_WAIT_SECOND: begin
          phase_next    = (rx_byte == cfg.second_header) ? PH_PAYLOAD : PH_WAIT_FIRST;
          progress_next = 2'd0;
        end
        PH_PAYLOAD: begin
          if (!full) begin
            unique case (progress)
              2'd0: begin
                if (rx_byte == RUN_A) progress_next = 2'd1;
                else do_store = 1'b1;
              end
              2'd1: begin
                if (rx_byte == RUN_B) progress_next = 2'd2;
                else do_store = 1'b1;
              end
              2'd2: begin
                if (rx_byte == RUN_C) progress_next = 2'd3;
                else do_store = 1'b1;
              end
              default: begin
                if (rx_byte == cfg.end_marker) do_close = 1'b1;
                else do_store = 1'b1;
              end
            endcase
            // flushed run plus the breaking byte
            k = {1'b0, progress} + 3'd1;
          end else if (rx_byte == cfg.end_marker) begin
            do_close = 1'b1;
          end
          if (do_store) begin
            progress_next = 2'd0;
            count_next    = count + {5'd0, nbytes};
          end
          if (do_close) begin
            phase_next    = PH_WAIT_FIRST;
            progress_next = 2'd0;
            count_next    = 8'd0;
          end
        end
        default: begin
          // code 3 behaves as waiting for the opening byte
          phase_next = (rx_byte == cfg.first_header) ? PH_WAIT_SECOND : PH_WAIT_FIRST;
        end
      endcase
    end
  end

  always_comb begin
    push         = fire && (do_store || do_close);
    cmd.is_close = do_close;
    cmd.n_m1     = nbytes[1:0] - 2'd1;
    cmd.start    = count;
    cmd.bytes[0] = (progress > 2'd0) ? RUN_A : rx_byte;
    cmd.bytes[1] = (progress > 2'd1) ? RUN_B : rx_byte;
    cmd.bytes[2] = (progress > 2'd2) ? RUN_C : rx_byte;
    cmd.bytes[3] = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_WAIT_FIRST;
      progress <= 2'd0;
      count    <= 8'd0;
    end else if (fire) begin
      phase    <= phase_next;
      progress <= progress_next;
      count    <= count_next;
    end
  end

endmodule

// ----- hdl/fpr_queue.sv -----
`timescale 1ns / 1ps
module fpr_queue
  import fpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full       = fill == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/fpr_back.sv -----
`timescale 1ns / 1ps
module fpr_back
  import fpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [7:0] position,
  output logic [7:0] packet_length,
  output logic       last
);

  logic [1:0] idx;
  logic       load;
  logic       cmd_end;

  assign load    = head_valid && (!res_valid || !res_stall);
  assign cmd_end = head_cmd.is_close || (idx == head_cmd.n_m1);
  assign pop     = load && cmd_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      res_valid <= 1'b0;
    end else if (load) begin
      idx       <= cmd_end ? 2'd0 : idx + 2'd1;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind          <= head_cmd.is_close;
      payload_byte  <= head_cmd.is_close ? 8'd0 : head_cmd.bytes[idx];
      position      <= head_cmd.is_close ? 8'd0 : head_cmd.start + {6'd0, idx};
      packet_length <= head_cmd.is_close ? head_cmd.start : 8'd0;
      last          <= cmd_end;
    end
  end

endmodule

// ----- test/framed_packet_receiver_tb.sv -----
`timescale 1ns / 1ps
module framed_packet_receiver_tb;
  import fpr_pkg::*;

  // run shape
  localparam int N_PHASES        = 11;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int SETTLE_CYCLES   = 12;    // byte in flight that makes no result
  localparam int STUCK_LIMIT     = 2000;  // cycles with no handshake at all
  localparam int MAX_REPORTS     = 10;

  // result kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  // register index past the end of the map, must be dropped by the block
  localparam logic [2:0] REG_UNUSED = 3'd5;

  // framing state of the predictor
  typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_BODY} frame_phase_t;
  typedef enum logic [1:0] {ESC_IDLE, ESC_A, ESC_AB, ESC_ABC} esc_run_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] pos;
    logic [7:0] len;
    logic       last;
  } fpr_result_t;

  // directed rows: either a register write or a link byte
  typedef enum logic {ROW_BYTE, ROW_REG} row_t;
  // how a byte row is checked: predictor, no result, or one typed-in result
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    row_t       op;
    logic [2:0] idx;
    logic [7:0] val;
    chk_t       chk;
    logic       k;
    logic [7:0] d;
    logic [7:0] p;
    logic [7:0] n;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_byte;
  logic       res_valid;
  logic       res_stall;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] position;
  logic [7:0] packet_length;
  logic       last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  // register mirror
  logic       m_enable;
  logic [7:0] m_max_len;
  logic [7:0] m_first;
  logic [7:0] m_second;
  logic [7:0] m_end;

  // framing mirror
  frame_phase_t m_phase;
  esc_run_t     m_esc;
  logic [7:0]   m_count;

  fpr_result_t step_out[$];      // results of the byte being decoded
  fpr_result_t decoded_due[$];   // results still owed by the block, oldest first
  logic [7:0]  rx_plan[$];       // link bytes of the current random phase

  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;
  bit          quiet;            // no idling on either side

  // directed part: defaults first, then escape runs, limits, disable, new framing bytes
  dir_row_t dir_tab [31] = '{
    '{ROW_BYTE, 3'd0, 8'h01, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h02, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h00, CHK_ONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hFF, CHK_ONE, KIND_BYTE, 8'hFF, 8'h01, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hAA, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h11, CHK_MODEL, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hAA, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hBB, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h22, CHK_MODEL, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hAA, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hBB, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hCC, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h33, CHK_MODEL, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_REG, REG_MAX_LENGTH, 8'd12, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hAA, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h55, CHK_ONE, KIND_BYTE, 8'hAA, 8'd11, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hAA, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h04, CHK_ONE, KIND_CLOSE, 8'h00, 8'h00, 8'd12},
    '{ROW_BYTE, 3'd0, 8'h01, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h07, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_REG, REG_ENABLE, 8'd0, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h01, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_REG, REG_ENABLE, 8'd1, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_REG, REG_MAX_LENGTH, 8'd0, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_REG, REG_FIRST_HEADER, 8'hFF, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_REG, REG_SECOND_HEADER, 8'h00, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_REG, REG_END_MARKER, 8'hAA, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_REG, REG_UNUSED, 8'h00, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hFF, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'h00, CHK_NONE, KIND_BYTE, 8'h00, 8'h00, 8'h00},
    '{ROW_BYTE, 3'd0, 8'hAA, CHK_ONE, KIND_CLOSE, 8'h00, 8'h00, 8'h00}
  };

  framed_packet_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .position      (position),
    .packet_length (packet_length),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // register write as the block sees it, unknown indexes dropped
  task automatic apply_reg(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      REG_ENABLE:        m_enable = val[0];
      REG_MAX_LENGTH:    m_max_len = val;
      REG_FIRST_HEADER:  m_first = val;
      REG_SECOND_HEADER: m_second = val;
      REG_END_MARKER:    m_end = val;
      default: ;
    endcase
  endtask

  // store one payload byte if there is room, past the limit it vanishes
  task automatic keep_byte(input logic [7:0] b);
    if (m_count < m_max_len) begin
      step_out.push_back('{KIND_BYTE, b, m_count, 8'd0, 1'b0});
      m_count = m_count + 8'd1;
    end
  endtask

  task automatic close_frame();
    step_out.push_back('{KIND_CLOSE, 8'd0, 8'd0, m_count, 1'b0});
    m_count = 8'd0;
    m_esc = ESC_IDLE;
    m_phase = PH_FIRST;
  endtask

  // decode one link byte into step_out, last flag on the final result
  task automatic decode_rx_byte(input logic [7:0] b);
    step_out.delete();
    if (m_enable) begin
      case (m_phase)
        PH_SECOND: begin
          m_phase = (b == m_second) ? PH_BODY : PH_FIRST;
          m_esc = ESC_IDLE;
        end
        PH_BODY: begin
          if (m_count < m_max_len) begin
            case (m_esc)
              ESC_A: begin
                if (b == RUN_B) begin
                  m_esc = ESC_AB;
                end else begin
                  keep_byte(RUN_A);
                  keep_byte(b);
                  m_esc = ESC_IDLE;
                end
              end
              ESC_AB: begin
                if (b == RUN_C) begin
                  m_esc = ESC_ABC;
                end else begin
                  keep_byte(RUN_A);
                  keep_byte(RUN_B);
                  keep_byte(b);
                  m_esc = ESC_IDLE;
                end
              end
              ESC_ABC: begin
                if (b == m_end) begin
                  close_frame();
                end else begin
                  keep_byte(RUN_A);
                  keep_byte(RUN_B);
                  keep_byte(RUN_C);
                  keep_byte(b);
                  m_esc = ESC_IDLE;
                end
              end
              default: begin
                if (b == RUN_A) m_esc = ESC_A;
                else keep_byte(b);
              end
            endcase
          end else if (b == m_end) begin
            // buffer full: only the end byte counts, a pending run is ignored
            close_frame();
          end
        end
        default: m_phase = (b == m_first) ? PH_SECOND : PH_FIRST;
      endcase
    end
    if (step_out.size() > 0) step_out[$].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- drivers

  // present one byte, hold it until taken, then log what the block owes
  task automatic send_rx(input logic [7:0] b, input chk_t chk, input fpr_result_t typed);
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    decode_rx_byte(b);
    case (chk)
      CHK_NONE: ;
      CHK_ONE: decoded_due.push_back(typed);
      default: foreach (step_out[i]) decoded_due.push_back(step_out[i]);
    endcase
    // random gap on the sending side
    if (!quiet && $urandom_range(0, 3) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // register write; cfg_valid stays up so writes can go back to back
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  // let every owed result drain, then give a silent byte time to finish
  task automatic quiesce();
    rx_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_header();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one frame of plan, mostly well formed with escape runs inside the body
  task automatic plan_frame();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      // line noise
      repeat ($urandom_range(1, 4)) rx_plan.push_back(8'($urandom));
    end else begin
      rx_plan.push_back(m_first);
      if (sel == 1) begin
        // broken second header, flip at least one bit
        rx_plan.push_back(m_second ^ 8'($urandom_range(1, 255)));
      end else begin
        rx_plan.push_back(m_second);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 9))
            0: rx_plan.push_back(RUN_A);
            1: begin
              rx_plan.push_back(RUN_A);
              rx_plan.push_back(RUN_B);
            end
            2: begin
              rx_plan.push_back(RUN_A);
              rx_plan.push_back(RUN_B);
              rx_plan.push_back(RUN_C);
            end
            3: rx_plan.push_back(m_end);
            default: rx_plan.push_back(8'($urandom));
          endcase
        end
        // most frames close, some are left hanging
        if (sel != 2) begin
          rx_plan.push_back(RUN_A);
          rx_plan.push_back(RUN_B);
          rx_plan.push_back(RUN_C);
          rx_plan.push_back(m_end);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- result check

  task automatic report_mismatch(input string what, input fpr_result_t want,
                                 input fpr_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s: exp kind=%0d byte=%02h pos=%0d len=%0d last=%0d | %s",
               $time, what, want.kind, want.data, want.pos, want.len, want.last,
               $sformatf("got kind=%0d byte=%02h pos=%0d len=%0d last=%0d",
                         got.kind, got.data, got.pos, got.len, got.last));
  endtask

  // each taken result against the oldest owed one, field by field
  always @(posedge clk) begin : check_results
    fpr_result_t got;
    fpr_result_t want;
    if (rst === 1'b0 && res_valid === 1'b1 && res_stall === 1'b0) begin
      got = '{kind, payload_byte, position, packet_length, last};
      if (decoded_due.size() == 0) begin
        report_mismatch("result with nothing owed", '0, got);
      end else begin
        want = decoded_due.pop_front();
        if (got.kind !== want.kind || got.data !== want.data || got.pos !== want.pos ||
            got.len !== want.len || got.last !== want.last)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if ((rx_valid && !rx_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("framed_packet_receiver_tb: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // result side stalls in bursts, with long free stretches between
  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        res_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    quiet = 1'b0;
    rst <= 1'b1;
    rx_valid <= 1'b0;
    rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ENABLE;
    cfg_data <= 8'h00;

    // register and framing state after reset
    m_enable = 1'b1;
    m_max_len = 8'd255;
    m_first = 8'h01;
    m_second = 8'h02;
    m_end = 8'h04;
    m_phase = PH_FIRST;
    m_esc = ESC_IDLE;
    m_count = 8'd0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table; writes only once the block has gone quiet
    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_REG) begin
        if (i == 0 || dir_tab[i - 1].op != ROW_REG) quiesce();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        cfg_valid <= 1'b0;
        send_rx(dir_tab[i].val, dir_tab[i].chk,
                '{dir_tab[i].k, dir_tab[i].d, dir_tab[i].p, dir_tab[i].n, 1'b1});
      end
    end

    // random phases, each with fresh framing bytes and limit
    for (int ph = 0; ph < N_PHASES; ph++) begin
      quiesce();
      quiet = (ph == N_PHASES - 1);
      write_reg(REG_ENABLE, (ph == 4) ? 8'd0 : 8'd1);
      case ($urandom_range(0, 7))
        0: write_reg(REG_MAX_LENGTH, 8'd0);
        1: write_reg(REG_MAX_LENGTH, 8'd1);
        2: write_reg(REG_MAX_LENGTH, 8'd255);
        3: write_reg(REG_MAX_LENGTH, 8'd2);
        default: write_reg(REG_MAX_LENGTH, 8'($urandom_range(3, 12)));
      endcase
      if (ph == 0) begin
        write_reg(REG_FIRST_HEADER, 8'h01);
        write_reg(REG_SECOND_HEADER, 8'h02);
        write_reg(REG_END_MARKER, 8'h04);
      end else begin
        write_reg(REG_FIRST_HEADER, pick_header());
        write_reg(REG_SECOND_HEADER, pick_header());
        case ($urandom_range(0, 5))
          0: write_reg(REG_END_MARKER, RUN_A);
          1: write_reg(REG_END_MARKER, RUN_C);
          2: write_reg(REG_END_MARKER, 8'hFF);
          default: write_reg(REG_END_MARKER, 8'($urandom));
        endcase
      end
      if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), 8'($urandom));
      cfg_valid <= 1'b0;

      // cut at the phase size, so a frame is often left open across the next writes
      rx_plan.delete();
      while (rx_plan.size() < ITEMS_PER_PHASE) plan_frame();
      for (int j = 0; j < ITEMS_PER_PHASE; j++) send_rx(rx_plan[j], CHK_MODEL, '0);
    end

    quiesce();
    if (mismatches == 0 && decoded_due.size() == 0) begin
      $display("framed_packet_receiver_tb: PASS");
    end else begin
      $display("framed_packet_receiver_tb: FAIL");
    end
    $finish;
  end

endmodule
